### hdl/html_whitespace_minifier_assert.svh
// Assertion macros shared by the minifier RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef HTML_WHITESPACE_MINIFIER_ASSERT_SVH
`define HTML_WHITESPACE_MINIFIER_ASSERT_SVH

// The expression must hold at every clock edge out of reset.
`define HWM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define HWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define HWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/hwm_pkg.sv
// Package for the HTML whitespace minifier: constants, keywords and item type.
// No dependencies; used by every module of the block.
`default_nettype none

package hwm_pkg;

  // Default lookahead window depth in bytes.
  localparam int unsigned LOOKAHEAD = 11;
  // Longest keyword the front end compares against.
  localparam int unsigned KW_MAX = 11;
  // Depth of the queue between the front end and the back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Keywords, first character in the highest byte, padded with zeros below.
  localparam logic [8*KW_MAX-1:0] KW_COPEN   = {"<!--", 56'd0};
  localparam logic [8*KW_MAX-1:0] KW_CCLOSE  = {"-->", 64'd0};
  localparam logic [8*KW_MAX-1:0] KW_PRE_O   = {"<pre", 56'd0};
  localparam logic [8*KW_MAX-1:0] KW_TXT_O   = {"<textarea", 16'd0};
  localparam logic [8*KW_MAX-1:0] KW_CODE_O  = {"<code", 48'd0};
  localparam logic [8*KW_MAX-1:0] KW_PRE_C   = {"</pre>", 40'd0};
  localparam logic [8*KW_MAX-1:0] KW_TXT_C   = "</textarea>";
  localparam logic [8*KW_MAX-1:0] KW_CODE_C  = {"</code>", 32'd0};

  // Single characters the back end reacts to.
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One classified byte, or the end-of-document marker, handed to the back end.
  typedef struct packed {
    logic [7:0] data;
    logic       c_open;   // "<!--" starts at this byte
    logic       c_close;  // "-->" starts at this byte
    logic       p_open;   // an opening preserved tag starts here
    logic       p_close;  // a closing preserved tag starts here
    logic       eod;      // end marker, carries no byte
  } hwm_item_t;

endpackage

`default_nettype wire

### hdl/html_whitespace_minifier.sv
// A byte's result passes from the window front via the queue to the output register. A
// byte reaches the window front when Lookahead-1 later bytes are accepted or at flush.
// Throughput: one byte per cycle unless the output stalls, set by the back-end update.
// After the last byte, the input stalls while up to Lookahead pending bytes and the end
// marker drain at one per cycle unless the output stalls. Reset is asynchronous, active
// low, and clears all control state; the window and queue payload hold no reset value.
`default_nettype none

module html_whitespace_minifier #(
  parameter int unsigned Lookahead = hwm_pkg::LOOKAHEAD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // is_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] has_byte
  output logic       m_axis_tlast    // end_of_doc
);
  import hwm_pkg::*;

  hwm_item_t fr_item;
  hwm_item_t q_item;
  logic      fr_push;
  logic      q_ready;
  logic      q_valid;
  logic      bk_pop;

  // Window and keyword classification.
  hwm_front #(
    .Lookahead (Lookahead)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .item_push_o   (fr_push),
    .item_o        (fr_item),
    .item_ready_i  (q_ready)
  );

  // Decoupling queue.
  hwm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_item),
    .pop_i   (bk_pop)
  );

  // Minifier state and output register.
  hwm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_pop_o    (bk_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### hdl/hwm_fifo.sv
// Short queue of classified items between the front end and the back end.
// Depends on hwm_pkg for the item type and the queue depth.
`default_nettype none
`include "html_whitespace_minifier_assert.svh"

module hwm_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hwm_pkg::hwm_item_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output hwm_pkg::hwm_item_t data_o,
  input  logic              pop_i
);
  import hwm_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  hwm_item_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage is payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `HWM_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CntW'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

### hdl/hwm_front.sv
// Front end: lookahead window, keyword matching and document flush.
// Depends on hwm_pkg for keywords and the item type.
`default_nettype none
`include "html_whitespace_minifier_assert.svh"

module hwm_front #(
  parameter int unsigned Lookahead = hwm_pkg::LOOKAHEAD
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
  input  logic              s_axis_tlast,   // is_last
  output logic              item_push_o,
  output hwm_pkg::hwm_item_t item_o,
  input  logic              item_ready_i
);
  import hwm_pkg::*;

  localparam int unsigned FillW = $clog2(Lookahead + 1);

  // Does the keyword of length len start at the window front?
  function automatic logic kw_hit(input logic [8*KW_MAX-1:0] win,
                                  input logic [KW_MAX-1:0]   vld,
                                  input logic [8*KW_MAX-1:0] kw,
                                  input int unsigned         len,
                                  input logic                fold);
    logic       hit;
    logic [7:0] c;
    hit = 1'b1;
    for (int unsigned i = 0; i < KW_MAX; i++) begin
      if (i < len) begin
        c = win[8*i +: 8];
        if (fold && (c inside {[8'h41:8'h5A]})) begin
          c = c + 8'd32;
        end
        hit = hit && vld[i] && (c == kw[8*(KW_MAX-1-i) +: 8]);
      end
    end
    return hit;
  endfunction

  logic [7:0]       win_q [Lookahead];
  logic [7:0]       win_d [Lookahead];
  logic [FillW-1:0] fill_q, fill_d;
  logic             flush_q, flush_d;
  logic             full, have_front, pop, push_end, acc;
  logic [FillW-1:0] wpos;
  logic [8*KW_MAX-1:0] front_win;
  logic [KW_MAX-1:0]   front_vld;

  // Handshake and window control.
  assign full          = (fill_q == FillW'(Lookahead));
  assign have_front    = full || (flush_q && (fill_q != '0));
  assign pop           = have_front && item_ready_i;
  assign push_end      = flush_q && (fill_q == '0) && item_ready_i;
  assign s_axis_tready = !flush_q && (!full || pop);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign wpos          = fill_q - FillW'(pop);
  assign item_push_o   = pop || push_end;

  // Front bytes and their valid bits for the keyword compares.
  always_comb begin
    for (int unsigned i = 0; i < KW_MAX; i++) begin
      front_win[8*i +: 8] = win_q[i];
      front_vld[i]        = (FillW'(i) < fill_q);
    end
  end

  // Classify the byte at the window front; the end marker carries no byte.
  always_comb begin
    item_o.data    = push_end ? 8'h00 : win_q[0];
    item_o.c_open  = kw_hit(front_win, front_vld, KW_COPEN, 4, 1'b0);
    item_o.c_close = kw_hit(front_win, front_vld, KW_CCLOSE, 3, 1'b0);
    item_o.p_open  = kw_hit(front_win, front_vld, KW_PRE_O, 4, 1'b1)
                  || kw_hit(front_win, front_vld, KW_TXT_O, 9, 1'b1)
                  || kw_hit(front_win, front_vld, KW_CODE_O, 5, 1'b1);
    item_o.p_close = kw_hit(front_win, front_vld, KW_PRE_C, 6, 1'b1)
                  || kw_hit(front_win, front_vld, KW_TXT_C, 11, 1'b1)
                  || kw_hit(front_win, front_vld, KW_CODE_C, 7, 1'b1);
    item_o.eod     = push_end;
  end

  // Shift on pop and write the accepted byte behind the last pending one.
  always_comb begin
    for (int unsigned i = 0; i < Lookahead; i++) begin
      win_d[i] = win_q[i];
      if (pop && (i < Lookahead - 1)) begin
        win_d[i] = win_q[i+1];
      end
      if (acc && (FillW'(i) == wpos)) begin
        win_d[i] = s_axis_tdata;
      end
    end
    fill_d  = fill_q - FillW'(pop) + FillW'(acc);
    flush_d = flush_q;
    if (acc && s_axis_tlast) begin
      flush_d = 1'b1;
    end else if (push_end) begin
      flush_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  `HWM_ASSERT_ALWAYS(a_fill_range, fill_q <= FillW'(Lookahead), "window fill beyond depth")
  `HWM_ASSERT_NEXT(a_last_flush, acc && s_axis_tlast, flush_q && !s_axis_tready,
                   "no flush after the last byte")
  `HWM_ASSERT_SAME(a_end_empty, item_push_o && item_o.eod, fill_q == '0,
                   "end marker sent with bytes pending")

endmodule

`default_nettype wire

### hdl/hwm_back.sv
// Back end: comment, preserve, tag, quote and whitespace state plus output register.
// Depends on hwm_pkg for the item type and character codes.
`default_nettype none
`include "html_whitespace_minifier_assert.svh"

module hwm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  hwm_pkg::hwm_item_t item_i,
  output logic              item_pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tuser,   // has_byte
  output logic              m_axis_tlast    // end_of_doc
);
  import hwm_pkg::*;

  logic [1:0] skip_q, skip_d;
  logic       comment_q, comment_d;
  logic       preserve_q, preserve_d;
  logic       tag_q, tag_d;
  logic       quote_q, quote_d;
  logic [7:0] qmark_q, qmark_d;
  logic       space_q, space_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       ohas_q, ohas_d;
  logic       oeod_q, oeod_d;
  logic       emit;
  logic [7:0] ebyte;
  logic [7:0] c;
  logic       pres;

  assign item_pop_o    = item_valid_i && (!ovalid_q || m_axis_tready);
  assign c             = item_i.data;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tuser  = ohas_q;
  assign m_axis_tlast  = oeod_q;

  // Handle one request from the queue and decide what it emits.
  always_comb begin
    skip_d     = skip_q;
    comment_d  = comment_q;
    preserve_d = preserve_q;
    tag_d      = tag_q;
    quote_d    = quote_q;
    qmark_d    = qmark_q;
    space_d    = space_q;
    emit       = 1'b0;
    ebyte      = c;
    pres       = preserve_q;
    if (item_i.eod) begin
      // End of document: emit the marker and return to reset state.
      skip_d     = '0;
      comment_d  = 1'b0;
      preserve_d = 1'b0;
      tag_d      = 1'b0;
      quote_d    = 1'b0;
      qmark_d    = '0;
      space_d    = 1'b0;
      emit       = 1'b1;
      ebyte      = 8'h00;
    end else if (skip_q != '0) begin
      skip_d = skip_q - 2'd1;
    end else if (!quote_q && item_i.c_open) begin
      comment_d = 1'b1;
      skip_d    = 2'd3;
    end else if (comment_q && item_i.c_close) begin
      comment_d = 1'b0;
      skip_d    = 2'd2;
    end else if (!comment_q) begin
      if (item_i.p_open) begin
        pres = 1'b1;
      end
      if (item_i.p_close) begin
        pres = 1'b0;
      end
      preserve_d = pres;
      if (pres) begin
        emit = 1'b1;
      end else if ((c == CH_LT) || (c == CH_GT)) begin
        tag_d   = (c == CH_LT);
        space_d = 1'b0;
        emit    = 1'b1;
      end else begin
        // Quote tracking inside a tag; a quote left open survives the tag end.
        if (tag_q && ((c == CH_DQ) || (c == CH_SQ))) begin
          if (!quote_q) begin
            quote_d = 1'b1;
            qmark_d = c;
          end else if (c == qmark_q) begin
            quote_d = 1'b0;
          end
        end
        if (tag_q && quote_d) begin
          emit = 1'b1;
        end else if (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}) begin
          if (!space_q) begin
            space_d = 1'b1;
            emit    = 1'b1;
            ebyte   = CH_SPACE;
          end
        end else begin
          space_d = 1'b0;
          emit    = 1'b1;
        end
      end
    end
  end

  // Output register: loads on a popped request, drains when taken.
  always_comb begin
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    ohas_d   = ohas_q;
    oeod_d   = oeod_q;
    if (item_pop_o) begin
      ovalid_d = emit;
      obyte_d  = ebyte;
      ohas_d   = !item_i.eod;
      oeod_d   = item_i.eod;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q     <= '0;
      comment_q  <= 1'b0;
      preserve_q <= 1'b0;
      tag_q      <= 1'b0;
      quote_q    <= 1'b0;
      qmark_q    <= '0;
      space_q    <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (item_pop_o) begin
        skip_q     <= skip_d;
        comment_q  <= comment_d;
        preserve_q <= preserve_d;
        tag_q      <= tag_d;
        quote_q    <= quote_d;
        qmark_q    <= qmark_d;
        space_q    <= space_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    ohas_q  <= ohas_d;
    oeod_q  <= oeod_d;
  end

  `HWM_ASSERT_SAME(a_marker_bare, m_axis_tvalid && m_axis_tlast,
                   !m_axis_tuser && (m_axis_tdata == 8'h00), "end marker carries a byte")
  `HWM_ASSERT_NEXT(a_marker_clears, item_pop_o && item_i.eod,
                   !comment_q && !preserve_q && !quote_q && (skip_q == '0),
                   "state not cleared after end marker")

endmodule

`default_nettype wire

### tb/html_whitespace_minifier_checker.sv
// Checker for the HTML whitespace minifier: watches both stream channels,
// predicts the minified bytes and compares them. Depends on hwm_pkg.

module html_whitespace_minifier_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // is_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic        m_axis_tuser,   // [0] has_byte
  input  logic        m_axis_tlast,   // end_of_doc
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned WinDepth = hwm_pkg::LOOKAHEAD;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       eod;
  } min_result_t;

  // Predicted results, oldest first.
  min_result_t minified_q[$];
  min_result_t want;

  // Predictor state.
  logic [7:0]  win [WinDepth];
  int unsigned fill = 0;
  int unsigned skip_cnt = 0;
  bit          comment_on = 1'b0;
  bit          in_preserve = 1'b0;
  bit          in_tag = 1'b0;
  bit          in_quote = 1'b0;
  logic [7:0]  quote_ch = 8'h00;
  bit          last_space = 1'b0;
  int unsigned fails = 0;

  function automatic void clear_state();
    fill        = 0;
    skip_cnt    = 0;
    comment_on  = 1'b0;
    in_preserve = 1'b0;
    in_tag      = 1'b0;
    in_quote    = 1'b0;
    quote_ch    = 8'h00;
    last_space  = 1'b0;
  endfunction

  function automatic void emit(logic [7:0] ch, logic has, logic eod);
    minified_q.push_back('{ch, has, eod});
  endfunction

  // True when the keyword sits at the window front; fold ignores letter case.
  function automatic bit starts_with(string kw, bit fold);
    logic [7:0] c;
    for (int i = 0; i < kw.len(); i++) begin
      if (i >= fill) return 1'b0;
      c = win[i];
      if (fold && c >= "A" && c <= "Z") c = c + 8'd32;
      if (c != kw[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Space, tab, line feed, vertical tab, form feed and carriage return.
  function automatic bit is_blank(logic [7:0] c);
    return c == hwm_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Decide what the byte at the window front turns into.
  function automatic void minify_front();
    logic [7:0] c;
    c = win[0];
    if (skip_cnt > 0) begin
      skip_cnt--;
      return;
    end
    if (!in_quote && starts_with("<!--", 1'b0)) begin
      comment_on = 1'b1;
      skip_cnt   = 3;
      return;
    end
    if (comment_on && starts_with("-->", 1'b0)) begin
      comment_on = 1'b0;
      skip_cnt   = 2;
      return;
    end
    if (comment_on) return;

    if (starts_with("<pre", 1'b1) || starts_with("<textarea", 1'b1) ||
        starts_with("<code", 1'b1)) in_preserve = 1'b1;
    if (starts_with("</pre>", 1'b1) || starts_with("</textarea>", 1'b1) ||
        starts_with("</code>", 1'b1)) in_preserve = 1'b0;
    if (in_preserve) begin
      emit(c, 1'b1, 1'b0);
      return;
    end

    if (c == hwm_pkg::CH_LT || c == hwm_pkg::CH_GT) begin
      in_tag     = (c == hwm_pkg::CH_LT);
      last_space = 1'b0;
      emit(c, 1'b1, 1'b0);
      return;
    end

    // Quoted attribute values inside a tag pass through untouched.
    if (in_tag && (c == hwm_pkg::CH_DQ || c == hwm_pkg::CH_SQ)) begin
      if (!in_quote) begin
        in_quote = 1'b1;
        quote_ch = c;
      end else if (c == quote_ch) begin
        in_quote = 1'b0;
      end
    end
    if (in_tag && in_quote) begin
      emit(c, 1'b1, 1'b0);
      return;
    end

    if (is_blank(c)) begin
      if (!last_space) begin
        last_space = 1'b1;
        emit(hwm_pkg::CH_SPACE, 1'b1, 1'b0);
      end
      return;
    end
    last_space = 1'b0;
    emit(c, 1'b1, 1'b0);
  endfunction

  function automatic void drop_front();
    if (fill > 0) begin
      for (int i = 0; i < WinDepth - 1; i++) win[i] = win[i + 1];
      fill--;
    end
  endfunction

  // One accepted input byte: fill the window, handle the front once full,
  // and on the last byte flush everything and close with the end marker.
  function automatic void predict_byte(logic [7:0] b, logic last);
    if (fill < WinDepth) begin
      win[fill] = b;
      fill++;
    end
    if (fill >= WinDepth) begin
      minify_front();
      drop_front();
    end
    if (last) begin
      while (fill > 0) begin
        minify_front();
        drop_front();
      end
      emit(8'h00, 1'b0, 1'b1);
      clear_state();
    end
  endfunction

  // Predict on every input request and compare every output request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_state();
      minified_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (minified_q.size() == 0) begin
          $display("%0t: unexpected result: out_byte %02h has_byte %b end_of_doc %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fails++;
        end else begin
          want = minified_q.pop_front();
          if (m_axis_tdata !== want.ch) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.ch, m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser !== want.has) begin
            $display("%0t: has_byte expected %b actual %b",
                     $time, want.has, m_axis_tuser);
            fails++;
          end
          if (m_axis_tlast !== want.eod) begin
            $display("%0t: end_of_doc expected %b actual %b",
                     $time, want.eod, m_axis_tlast);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= minified_q.size();
  end

endmodule

### tb/tb_html_whitespace_minifier.sv
// Top of the minifier testbench: clock, reset, HTML-like stimulus and verdict.
// Depends on hwm_pkg, html_whitespace_minifier and html_whitespace_minifier_checker.

module tb_html_whitespace_minifier;

  localparam int unsigned RandomBytes = 460;
  localparam int unsigned CycleLimit  = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned tx_idle_pct = 7;
  int unsigned rx_stall_pct = 58;
  int unsigned random_sent = 0;

  // Document under construction.
  logic [7:0]  doc_q[$];
  string       tag_names[6] = '{"pre", "textarea", "code", "div", "p", "span"};
  string       keep_names[3] = '{"pre", "textarea", "code"};
  string       comment_bits[5] = '{"<!-", "--", "->", "-->", "<!"};
  logic [7:0]  blank_chars[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  html_whitespace_minifier i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  html_whitespace_minifier_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock with a period of 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Offer one byte as a request, idling first at random; returns at a falling edge.
  task automatic send_char(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Send the built document, marking its final byte, and clear it.
  task automatic send_doc();
    for (int i = 0; i < doc_q.size(); i++) send_char(doc_q[i], i == doc_q.size() - 1);
    doc_q.delete();
  endtask

  // Append text; with mixed_case set, letters flip case at random.
  task automatic add_text(input string s, input bit mixed_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixed_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
          $urandom_range(0, 1)) c = c ^ 8'h20;
      doc_q.push_back(c);
    end
  endtask

  task automatic add_word(input int unsigned n);
    for (int i = 0; i < n; i++) doc_q.push_back(8'($urandom_range(8'h61, 8'h7A)) ^
                                                ($urandom_range(0, 3) == 0 ? 8'h20 : 8'h00));
  endtask

  task automatic add_blanks(input int unsigned n);
    for (int i = 0; i < n; i++) doc_q.push_back(blank_chars[$urandom_range(0, 5)]);
  endtask

  // Attribute with a quoted value, sometimes holding a '>' or '<!--', or left open.
  task automatic add_attr();
    logic [7:0] q;
    q = $urandom_range(0, 1) ? hwm_pkg::CH_DQ : hwm_pkg::CH_SQ;
    add_blanks(1);
    add_word($urandom_range(1, 4));
    add_text("=", 1'b0);
    doc_q.push_back(q);
    add_word($urandom_range(0, 3));
    add_blanks($urandom_range(0, 3));
    if ($urandom_range(0, 5) == 0) doc_q.push_back(hwm_pkg::CH_GT);
    if ($urandom_range(0, 4) == 0) add_text("<!--", 1'b0);
    add_word($urandom_range(0, 3));
    if ($urandom_range(0, 6) != 0) doc_q.push_back(q);
  endtask

  // One piece of HTML-like text: words, blank runs, tags, comments,
  // preserved blocks, broken keywords or raw noise.
  task automatic add_token();
    int unsigned kind;
    string nm;
    kind = $urandom_range(0, 99);
    nm   = tag_names[$urandom_range(0, 5)];
    if (kind < 20) begin
      add_word($urandom_range(1, 6));
    end else if (kind < 35) begin
      add_blanks($urandom_range(1, 4));
    end else if (kind < 50) begin
      add_text({"<", nm}, 1'b1);
      if ($urandom_range(0, 1)) add_attr();
      add_text(">", 1'b0);
    end else if (kind < 60) begin
      add_text({"</", nm, ">"}, 1'b1);
    end else if (kind < 72) begin
      add_text("<!--", 1'b0);
      add_word($urandom_range(0, 3));
      add_blanks($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) add_text("<pre>", 1'b1);
      add_word($urandom_range(0, 3));
      if ($urandom_range(0, 9) != 0) add_text("-->", 1'b0);
    end else if (kind < 80) begin
      add_text(comment_bits[$urandom_range(0, 4)], 1'b0);
    end else if (kind < 90) begin
      nm = keep_names[$urandom_range(0, 2)];
      add_text({"<", nm, ">"}, 1'b1);
      add_blanks($urandom_range(1, 3));
      add_word($urandom_range(1, 4));
      add_blanks($urandom_range(0, 3));
      if ($urandom_range(0, 7) != 0) add_text({"</", nm, ">"}, 1'b1);
    end else begin
      repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  initial begin
    int unsigned target;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extreme bytes alone, an unclosed comment cut at the end,
    // a quote left open across '>', and a preserved block in mixed case.
    doc_q.push_back(8'hFF);
    send_doc();
    doc_q.push_back(8'h01);
    send_doc();
    add_text("<!--", 1'b0);
    send_doc();
    add_text("<p'>  x", 1'b0);
    send_doc();
    add_text("<PRE> ", 1'b0);
    doc_q.push_back(8'h09);
    add_text("</pre>", 1'b0);
    send_doc();

    // Random documents, mostly well formed, a few shorter than the window.
    while (random_sent < RandomBytes) begin
      if (random_sent >= 2 * RandomBytes / 3) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end else if (random_sent >= RandomBytes / 3) begin
        tx_idle_pct  = 58;
        rx_stall_pct = 7;
      end
      target = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 10) : $urandom_range(11, 48);
      while (doc_q.size() < target) add_token();
      random_sent += doc_q.size();
      send_doc();
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the window depth plus pipeline for anything stray.
    while (pending != 0) @(negedge clk_i);
    repeat (2 * hwm_pkg::LOOKAHEAD + 8) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
